// File: sv/slnx_pkg.sv
// Package for the sequence length statistics block: item structs, codes,
// controller states and datapath operations. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slnx_pkg;

  localparam int MAX_SEQS    = 4096;
  localparam int LENGTH_BITS = 24;
  localparam int NX_BINS     = 101;
  localparam int STORE_AW    = $clog2(MAX_SEQS);
  localparam int COUNT_W     = 13;
  localparam int TOTAL_W     = 36;
  localparam int SUMSQ_W     = 60;
  localparam int GENOME_W    = 40;
  localparam int BIN_W       = 7;
  localparam int FIX_W       = 32;
  localparam int DIVD_W      = 68;
  localparam int DIVS_W      = 36;
  localparam int DIVC_W      = 7;
  localparam int SUB100_W    = 43;
  localparam int THR_W       = 47;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_SET   = 2'd3;

  localparam logic OPC_PUSH = 1'b0;
  localparam logic OPC_READ = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [LENGTH_BITS-1:0] seq_length;
    logic                   last_length;
    logic [BIN_W-1:0]       bin_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [TOTAL_W-1:0]     len_total;
    logic [COUNT_W-1:0]     seq_count;
    logic [LENGTH_BITS-1:0] len_min;
    logic [LENGTH_BITS-1:0] len_max;
    logic [LENGTH_BITS-1:0] len_mid;
    logic [FIX_W-1:0]       len_average;
    logic [FIX_W-1:0]       weighted_mean;
    logic [BIN_W-1:0]       bin_percent;
    logic [LENGTH_BITS-1:0] bin_length;
    logic [COUNT_W-1:0]     bin_count;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_MED_A, S_MED_B, S_MED_C, S_AVG_GO, S_AVG_RUN,
    S_WM_GO, S_WM_RUN, S_W_INIT, S_W_RD, S_W_ADD, S_W_BIN, S_FILL
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_RD_EMIT, OP_PUSH, OP_MED_A, OP_MED_B, OP_MED_C,
    OP_AVG_GO, OP_AVG_CAP, OP_WM_GO, OP_WM_CAP, OP_W_INIT, OP_W_RD, OP_W_ADD,
    OP_BIN_WR, OP_W_NEXT, OP_FILL_WR, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic is_read;
    logic push_ok;
    logic last;
    logic div_busy;
    logic bin_hit;
    logic more;
    logic x_done;
  } dp_status_t;

endpackage
`default_nettype wire

// File: sv/slnx_div.sv
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// Depends on slnx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slnx_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [slnx_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [slnx_pkg::DIVS_W-1:0]  divisor,
  output logic                              busy,
  output logic [slnx_pkg::FIX_W-1:0]        quotient
);

  logic [slnx_pkg::DIVS_W-1:0] rem_r;
  logic [slnx_pkg::DIVS_W-1:0] div_r;
  logic [slnx_pkg::DIVD_W-1:0] quo_r;
  logic [slnx_pkg::DIVC_W-1:0] cnt_r;
  logic [slnx_pkg::DIVS_W:0]   trial;
  logic                        take;

  assign trial = {rem_r, quo_r[slnx_pkg::DIVD_W-1]};
  assign take  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= slnx_pkg::DIVC_W'(slnx_pkg::DIVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= take ? slnx_pkg::DIVS_W'(trial - {1'b0, div_r})
                    : trial[slnx_pkg::DIVS_W-1:0];
      quo_r <= {quo_r[slnx_pkg::DIVD_W-2:0], take};
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r[slnx_pkg::FIX_W-1:0];

endmodule
`default_nettype wire

// File: sv/slnx_datapath.sv
// Datapath: length store, accumulators, divider, Nx walk and table, output
// register. Depends on slnx_pkg and slnx_div.
`timescale 1ns / 1ps
`default_nettype none
module slnx_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire slnx_pkg::dp_op_t                op,
  output slnx_pkg::dp_status_t                 st,
  input  wire slnx_pkg::in_item_t              in_data,
  input  wire logic                            cfg_we,
  input  wire logic [slnx_pkg::GENOME_W-1:0]   cfg_data,
  output logic                                 out_strobe,
  output slnx_pkg::out_item_t                  out_data
);

  localparam int LW = slnx_pkg::LENGTH_BITS;
  localparam int CW = slnx_pkg::COUNT_W;
  localparam int AW = slnx_pkg::STORE_AW;

  logic [LW-1:0]     store [0:slnx_pkg::MAX_SEQS-1];
  logic [LW+CW-1:0]  nx_mem [0:slnx_pkg::NX_BINS-1];

  slnx_pkg::in_item_t  in_r;
  slnx_pkg::out_item_t out_r;
  slnx_pkg::out_item_t sum_q_r;
  logic                out_strobe_r;

  logic [slnx_pkg::GENOME_W-1:0] genome_r;
  logic [CW-1:0]                 count_r;
  logic [slnx_pkg::TOTAL_W-1:0]  total_r;
  logic [slnx_pkg::SUMSQ_W-1:0]  sumsq_r;
  logic [2*LW-1:0]               sq_r;
  logic                          sq_pend_r;
  logic [LW-1:0]                 prev_r;
  logic [LW-1:0]                 first_r;
  logic                          set_ok_r;

  logic [LW-1:0]                 rd_data_r;
  logic [LW+CW-1:0]              nx_rd_r;
  logic [LW-1:0]                 med_a_r;
  logic [LW-1:0]                 med_b_r;
  logic [slnx_pkg::FIX_W-1:0]    avg_r;
  logic [slnx_pkg::FIX_W-1:0]    wm_r;

  logic [AW-1:0]                 i_r;
  logic [slnx_pkg::BIN_W-1:0]    x_r;
  logic [slnx_pkg::SUB100_W-1:0] sub100_r;
  logic [slnx_pkg::THR_W-1:0]    thr_r;
  logic [slnx_pkg::GENOME_W-1:0] ref_r;
  logic [LW-1:0]                 cur_r;
  logic [LW-1:0]                 last_len_r;
  logic [CW-1:0]                 last_rank_r;

  slnx_pkg::out_item_t  sum_v;
  slnx_pkg::out_item_t  out_nxt;
  slnx_pkg::in_item_t   in_nxt;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic [CW-1:0]        count_nxt;
  logic [slnx_pkg::TOTAL_W-1:0] total_nxt;
  logic [slnx_pkg::BIN_W-1:0]   bin_sat;
  logic [CW-1:0]        rank_v;
  logic [LW:0]          med_sum;
  logic                 div_start;
  logic [slnx_pkg::DIVD_W-1:0] div_dvd;
  logic [slnx_pkg::DIVS_W-1:0] div_dvs;
  logic                 div_busy;
  logic [slnx_pkg::FIX_W-1:0]  div_q;

  slnx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign div_start = (op == slnx_pkg::OP_AVG_GO) || (op == slnx_pkg::OP_WM_GO);
  assign div_dvd = (op == slnx_pkg::OP_AVG_GO)
                   ? {24'd0, total_r, 8'd0} : {sumsq_r, 8'd0};
  assign div_dvs = (op == slnx_pkg::OP_AVG_GO)
                   ? {23'd0, count_r} : total_r;

  assign count_nxt = count_r + 1'b1;
  assign total_nxt = total_r + slnx_pkg::TOTAL_W'(in_r.seq_length);
  assign bin_sat   = (in_data.bin_index > slnx_pkg::BIN_W'(slnx_pkg::NX_BINS - 1))
                     ? slnx_pkg::BIN_W'(slnx_pkg::NX_BINS - 1) : in_data.bin_index;
  assign rank_v    = CW'(i_r) + 1'b1;
  assign med_sum   = {1'b0, med_a_r} + {1'b0, med_b_r};

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = i_r;
    unique case (op)
      slnx_pkg::OP_MED_A: rd_addr = count_r[AW:1];
      slnx_pkg::OP_MED_B: rd_addr = AW'((count_r - 1'b1) >> 1);
      slnx_pkg::OP_W_RD:  rd_addr = i_r;
      default:            rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    sum_v               = '0;
    sum_v.status        = slnx_pkg::ST_OK;
    sum_v.len_total     = total_r;
    sum_v.seq_count     = count_r;
    sum_v.len_min       = prev_r;
    sum_v.len_max       = first_r;
    sum_v.len_mid       = med_sum[LW:1];
    sum_v.len_average   = avg_r;
    sum_v.weighted_mean = wm_r;
  end

  always_comb begin
    in_nxt           = in_data;
    in_nxt.bin_index = bin_sat;
  end

  always_comb begin
    out_nxt = '0;
    if (op == slnx_pkg::OP_FINISH) begin
      out_nxt = sum_v;
    end else if (op == slnx_pkg::OP_RD_EMIT) begin
      if (set_ok_r) begin
        out_nxt             = sum_q_r;
        out_nxt.bin_percent = in_r.bin_index;
        out_nxt.bin_length  = nx_rd_r[LW+CW-1:CW];
        out_nxt.bin_count   = nx_rd_r[CW-1:0];
      end else begin
        out_nxt.status = slnx_pkg::ST_NO_SET;
      end
    end else if (count_r == CW'(slnx_pkg::MAX_SEQS)) begin
      out_nxt.status    = slnx_pkg::ST_FULL;
      out_nxt.len_total = total_r;
      out_nxt.seq_count = count_r;
    end else if (!st.push_ok) begin
      out_nxt.status    = slnx_pkg::ST_UNSORTED;
      out_nxt.len_total = total_r;
      out_nxt.seq_count = count_r;
    end else begin
      out_nxt.status    = slnx_pkg::ST_OK;
      out_nxt.len_total = total_nxt;
      out_nxt.seq_count = count_nxt;
    end
  end

  always_comb begin
    st.is_read  = in_r.opcode == slnx_pkg::OPC_READ;
    st.push_ok  = (count_r != CW'(slnx_pkg::MAX_SEQS)) &&
                  !((count_r != '0) && (in_r.seq_length > prev_r));
    st.last     = in_r.last_length;
    st.div_busy = div_busy;
    st.bin_hit  = (x_r != slnx_pkg::BIN_W'(slnx_pkg::NX_BINS)) &&
                  (slnx_pkg::THR_W'(sub100_r) >= thr_r);
    st.more     = rank_v != count_r;
    st.x_done   = x_r == slnx_pkg::BIN_W'(slnx_pkg::NX_BINS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
    if ((op == slnx_pkg::OP_PUSH) && st.push_ok) begin
      store[count_r[AW-1:0]] <= in_r.seq_length;
    end
  end

  always_ff @(posedge clk) begin
    if (op == slnx_pkg::OP_LATCH) begin
      nx_rd_r <= nx_mem[bin_sat];
    end
    if (op == slnx_pkg::OP_BIN_WR) begin
      nx_mem[x_r] <= {cur_r, rank_v};
    end else if (op == slnx_pkg::OP_FILL_WR) begin
      nx_mem[x_r] <= {last_len_r, last_rank_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      genome_r     <= '0;
      count_r      <= '0;
      total_r      <= '0;
      sumsq_r      <= '0;
      sq_pend_r    <= 1'b0;
      prev_r       <= '0;
      set_ok_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (op == slnx_pkg::OP_RD_EMIT) || (op == slnx_pkg::OP_FINISH) ||
                      ((op == slnx_pkg::OP_PUSH) && !(st.push_ok && in_r.last_length));
      sq_pend_r    <= (op == slnx_pkg::OP_PUSH) && st.push_ok;
      if (cfg_we) begin
        genome_r <= cfg_data;
      end
      if (sq_pend_r) begin
        sumsq_r <= sumsq_r + slnx_pkg::SUMSQ_W'(sq_r);
      end
      unique case (op)
        slnx_pkg::OP_PUSH: begin
          if (st.push_ok) begin
            count_r <= count_nxt;
            total_r <= total_nxt;
            prev_r  <= in_r.seq_length;
          end
        end
        slnx_pkg::OP_FINISH: begin
          set_ok_r <= 1'b1;
          count_r  <= '0;
          total_r  <= '0;
          sumsq_r  <= '0;
          prev_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      slnx_pkg::OP_LATCH: in_r <= in_nxt;
      slnx_pkg::OP_RD_EMIT: out_r <= out_nxt;
      slnx_pkg::OP_PUSH: begin
        out_r <= out_nxt;
        if (st.push_ok) begin
          sq_r <= in_r.seq_length * in_r.seq_length;
          if (count_r == '0) begin
            first_r <= in_r.seq_length;
          end
        end
      end
      slnx_pkg::OP_MED_B: med_a_r <= rd_data_r;
      slnx_pkg::OP_MED_C: med_b_r <= rd_data_r;
      slnx_pkg::OP_AVG_CAP: avg_r <= div_q;
      slnx_pkg::OP_WM_CAP: wm_r <= (total_r == '0) ? '0 : div_q;
      slnx_pkg::OP_W_INIT: begin
        i_r      <= '0;
        x_r      <= '0;
        sub100_r <= '0;
        thr_r    <= '0;
        ref_r    <= (genome_r != '0) ? genome_r
                                     : slnx_pkg::GENOME_W'(total_r);
      end
      slnx_pkg::OP_W_ADD: begin
        cur_r    <= rd_data_r;
        sub100_r <= sub100_r +
                    slnx_pkg::SUB100_W'(rd_data_r) * slnx_pkg::SUB100_W'(100);
      end
      slnx_pkg::OP_BIN_WR: begin
        last_len_r  <= cur_r;
        last_rank_r <= rank_v;
        thr_r       <= thr_r + slnx_pkg::THR_W'(ref_r);
        x_r         <= x_r + 1'b1;
      end
      slnx_pkg::OP_W_NEXT: i_r <= i_r + 1'b1;
      slnx_pkg::OP_FILL_WR: x_r <= x_r + 1'b1;
      slnx_pkg::OP_FINISH: out_r <= out_nxt;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == slnx_pkg::OP_FINISH) begin
      sum_q_r <= sum_v;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for two cycles");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(slnx_pkg::MAX_SEQS))
    else $error("length count beyond store depth");
  a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (op == slnx_pkg::OP_BIN_WR || op == slnx_pkg::OP_FILL_WR) |->
      x_r < slnx_pkg::BIN_W'(slnx_pkg::NX_BINS))
    else $error("Nx bin write beyond table");
  a_div_idle_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (op == slnx_pkg::OP_AVG_CAP || op == slnx_pkg::OP_WM_CAP) |-> !div_busy)
    else $error("quotient taken while divider runs");
`endif

endmodule
`default_nettype wire

// File: sv/slnx_ctrl.sv
// Controller state machine that sequences push, read and the set finish.
// Depends on slnx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slnx_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire slnx_pkg::dp_status_t st,
  output slnx_pkg::dp_op_t          op,
  output logic                      busy
);

  slnx_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slnx_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = slnx_pkg::OP_NONE;
    unique case (state_r)
      slnx_pkg::S_IDLE: begin
        if (start) begin
          op        = slnx_pkg::OP_LATCH;
          state_nxt = slnx_pkg::S_DECIDE;
        end
      end
      slnx_pkg::S_DECIDE: begin
        if (st.is_read) begin
          op        = slnx_pkg::OP_RD_EMIT;
          state_nxt = slnx_pkg::S_IDLE;
        end else begin
          op        = slnx_pkg::OP_PUSH;
          state_nxt = (st.push_ok && st.last) ? slnx_pkg::S_MED_A : slnx_pkg::S_IDLE;
        end
      end
      slnx_pkg::S_MED_A: begin
        op        = slnx_pkg::OP_MED_A;
        state_nxt = slnx_pkg::S_MED_B;
      end
      slnx_pkg::S_MED_B: begin
        op        = slnx_pkg::OP_MED_B;
        state_nxt = slnx_pkg::S_MED_C;
      end
      slnx_pkg::S_MED_C: begin
        op        = slnx_pkg::OP_MED_C;
        state_nxt = slnx_pkg::S_AVG_GO;
      end
      slnx_pkg::S_AVG_GO: begin
        op        = slnx_pkg::OP_AVG_GO;
        state_nxt = slnx_pkg::S_AVG_RUN;
      end
      slnx_pkg::S_AVG_RUN: begin
        if (!st.div_busy) begin
          op        = slnx_pkg::OP_AVG_CAP;
          state_nxt = slnx_pkg::S_WM_GO;
        end
      end
      slnx_pkg::S_WM_GO: begin
        op        = slnx_pkg::OP_WM_GO;
        state_nxt = slnx_pkg::S_WM_RUN;
      end
      slnx_pkg::S_WM_RUN: begin
        if (!st.div_busy) begin
          op        = slnx_pkg::OP_WM_CAP;
          state_nxt = slnx_pkg::S_W_INIT;
        end
      end
      slnx_pkg::S_W_INIT: begin
        op        = slnx_pkg::OP_W_INIT;
        state_nxt = slnx_pkg::S_W_RD;
      end
      slnx_pkg::S_W_RD: begin
        op        = slnx_pkg::OP_W_RD;
        state_nxt = slnx_pkg::S_W_ADD;
      end
      slnx_pkg::S_W_ADD: begin
        op        = slnx_pkg::OP_W_ADD;
        state_nxt = slnx_pkg::S_W_BIN;
      end
      slnx_pkg::S_W_BIN: begin
        if (st.bin_hit) begin
          op = slnx_pkg::OP_BIN_WR;
        end else if (st.more) begin
          op        = slnx_pkg::OP_W_NEXT;
          state_nxt = slnx_pkg::S_W_RD;
        end else begin
          state_nxt = slnx_pkg::S_FILL;
        end
      end
      slnx_pkg::S_FILL: begin
        if (st.x_done) begin
          op        = slnx_pkg::OP_FINISH;
          state_nxt = slnx_pkg::S_IDLE;
        end else begin
          op = slnx_pkg::OP_FILL_WR;
        end
      end
      default: begin
        state_nxt = slnx_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = state_r != slnx_pkg::S_IDLE;

`ifndef SYNTH
  a_decide_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slnx_pkg::S_IDLE && start) |=> state_r == slnx_pkg::S_DECIDE)
    else $error("accepted item not dispatched");
  a_finish_from_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (op == slnx_pkg::OP_FINISH) |-> st.x_done)
    else $error("set finished before the Nx table was complete");
  a_wait_on_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slnx_pkg::S_AVG_RUN && st.div_busy) |=>
      state_r == slnx_pkg::S_AVG_RUN)
    else $error("left the divide wait early");
`endif

endmodule
`default_nettype wire

// File: sv/sequence_length_nx_stats_top.sv
// Push and read: the item is latched at start, dispatched in the decide state, and
// the result strobe is registered from there; the next item may start in the strobe cycle.
// Final push: the result strobe follows the median reads, the two bit-serial divides,
// the serial Nx walk over the single-port length store and the fill of the Nx table.
// Reset is synchronous: no finished set, reads report status 3 until one is.
// The receiver cannot stall; each result is valid for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module sequence_length_nx_stats_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire slnx_pkg::in_item_t            in_data,
  output logic                               out_strobe,
  output slnx_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [slnx_pkg::GENOME_W-1:0] cfg_data
);

  slnx_pkg::dp_op_t     op;
  slnx_pkg::dp_status_t st;

  slnx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  slnx_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .st         (st),
    .in_data    (in_data),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  assign cfg_ready = !busy;

endmodule
`default_nettype wire
